@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/gne_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types, codes and direction tables for the grid neighbor expander.
// ----------------------------------------------------------------------------
package gne_pkg;

    localparam int GRID_W_MAX_DEF = 64;
    localparam int GRID_H_MAX_DEF = 64;
    localparam int COST_BITS_DEF  = 16;

    localparam int OP_W       = 2;
    localparam int COORD_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int COST_OUT_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 7;
    localparam int REL_W      = COORD_W + 2;
    localparam int S_TDATA_W  = 3 * COORD_W;
    localparam int M_TDATA_W  = 2 * COORD_W + COST_OUT_W + 1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 2'd0,
        OP_GET  = 2'd1,
        OP_WALK = 2'd2,
        OP_CARD = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_OUTSIDE = 2'd1,
        STS_NONE    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_LEFT   = 3'd0,
        REG_GRID_TOP    = 3'd1,
        REG_GRID_WIDTH  = 3'd2,
        REG_GRID_HEIGHT = 3'd3,
        REG_DIAGONAL    = 3'd4,
        REG_CORNER_CUT  = 3'd5
    } cfg_reg_t;

    // direction slots: 0..3 cardinal, 4..7 diagonal, origin last
    typedef logic [3:0] dir_t;
    localparam dir_t DIR_FIRST     = 4'd0;
    localparam dir_t DIR_LAST_CARD = 4'd3;
    localparam dir_t DIR_LAST_ALL  = 4'd7;
    localparam dir_t DIR_ORIGIN    = 4'd8;

    typedef struct packed {
        status_t                 status;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic [COST_OUT_W-1:0]   cost;
        logic                    imp;
    } result_t;

    function automatic logic signed [1:0] step_dx(input dir_t dir);
        unique case (dir)
            4'd0:    step_dx = 2'sd1;
            4'd2:    step_dx = -2'sd1;
            4'd4:    step_dx = 2'sd1;
            4'd5:    step_dx = -2'sd1;
            4'd6:    step_dx = -2'sd1;
            4'd7:    step_dx = 2'sd1;
            default: step_dx = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] step_dy(input dir_t dir);
        unique case (dir)
            4'd1:    step_dy = -2'sd1;
            4'd3:    step_dy = 2'sd1;
            4'd4:    step_dy = 2'sd1;
            4'd5:    step_dy = -2'sd1;
            4'd6:    step_dy = 2'sd1;
            4'd7:    step_dy = -2'sd1;
            default: step_dy = 2'sd0;
        endcase
    endfunction

endpackage

@@ hdl/gne_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gne_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/grid_neighbor_expander.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// grid_neighbor_expander
// Per-tile Q8.8 cost store with set, get and 4/8-connected neighbor listing.
// ----------------------------------------------------------------------------
// After reset the block clears its cost store to 1.0, one entry per cycle,
// all GRID_W_MAX*GRID_H_MAX entries (4096 by default); s_tready stays low
// until then. All store reads go through one RAM read port behind a shared
// address unit that steps each tile through offset, bounds/index and evaluate.
// Set and get touch the origin tile only; a cardinal or plain neighbor query
// reads the origin and four tiles; with diagonals it reads nine tiles. Output
// stalls can hold a query in its evaluate or finish state. Results of one item
// come out in right, up, left, down, then diagonal order, the final one with m_tlast.
// ----------------------------------------------------------------------------
module grid_neighbor_expander #(
    parameter int GRID_W_MAX = gne_pkg::GRID_W_MAX_DEF,
    parameter int GRID_H_MAX = gne_pkg::GRID_H_MAX_DEF,
    parameter int COST_BITS  = gne_pkg::COST_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gne_pkg::S_TDATA_W-1:0]   s_tdata,  // tile_x, tile_y, new_cost
    input  logic [gne_pkg::OP_W-1:0]        s_tuser,  // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gne_pkg::M_TDATA_W-1:0]   m_tdata,  // out_x, out_y, cost_value, impassable
    output logic [gne_pkg::STATUS_W-1:0]    m_tuser,  // status
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [gne_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gne_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import gne_pkg::*;

    localparam int DEPTH  = GRID_W_MAX * GRID_H_MAX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XW     = $clog2(GRID_W_MAX);
    localparam int YW     = $clog2(GRID_H_MAX);

    localparam logic [REL_W-1:0]     WLIM_MAX   = REL_W'(GRID_W_MAX);
    localparam logic [REL_W-1:0]     HLIM_MAX   = REL_W'(GRID_H_MAX);
    localparam logic [ADDR_W-1:0]    ROW_PITCH  = ADDR_W'(GRID_W_MAX);
    localparam logic [ADDR_W-1:0]    CLR_LAST   = ADDR_W'(DEPTH - 1);
    localparam logic signed [32:0]   COST_MAX33 = (33'sd1 <<< (COST_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0]   COST_MIN33 = -COST_MAX33 - 33'sd1;
    localparam logic signed [32:0]   RESET33    = (COST_MAX33 < 33'sd256) ? COST_MAX33
                                                                          : 33'sd256;
    localparam logic [COST_BITS-1:0] RESET_COST = RESET33[COST_BITS-1:0];
    localparam logic signed [32:0]   GET_MAX33  = 33'sd32767;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_LOOK,
        ST_EVAL,
        ST_FINISH
    } state_t;

    function automatic logic [REL_W-1:0] dim_limit(input logic [DIM_W-1:0] v,
                                                   input logic [REL_W-1:0] vmax);
        if (v == '0) begin
            dim_limit = REL_W'(1);
        end else if (REL_W'(v) > vmax) begin
            dim_limit = vmax;
        end else begin
            dim_limit = REL_W'(v);
        end
    endfunction

    function automatic logic [COST_BITS-1:0] sat_cost(input logic [COORD_W-1:0] c);
        logic signed [32:0] w;
        w = {{(33 - COORD_W){c[COORD_W-1]}}, c};
        if (w > COST_MAX33) begin
            w = COST_MAX33;
        end else if (w < COST_MIN33) begin
            w = COST_MIN33;
        end
        sat_cost = w[COST_BITS-1:0];
    endfunction

    // control and configuration
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    dir_t                 dir_reg, dir_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [COORD_W-1:0]   left_reg, left_next, top_reg, top_next;
    logic [REL_W-1:0]     wlim_reg, wlim_next, hlim_reg, hlim_next;
    logic                 diag_reg, diag_next, cut_reg, cut_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic [COORD_W-1:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic [COST_BITS-1:0] cost_in_reg, cost_in_next;
    logic [COORD_W-1:0]   nx_reg, nx_next, ny_reg, ny_next;
    logic [REL_W-1:0]     rx_reg, rx_next, ry_reg, ry_next;
    logic                 fit_reg, fit_next;
    logic                 inb_reg, inb_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 owall_reg, owall_next;
    logic [3:0]           cwall_reg, cwall_next;
    result_t              pend_reg, pend_next;
    result_t              out_reg, out_next;
    logic                 out_last_reg, out_last_next;

    // datapath
    logic signed [1:0]    dx, dy;
    logic [COORD_W:0]     nx_full, ny_full;
    logic                 inb;
    logic [ADDR_W-1:0]    idx;
    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [COST_BITS-1:0] mem_wdata, mem_rdata;
    logic signed [32:0]   rd33;
    logic                 cell_wall, check, corner, pass, is_origin, out_free, stall;
    dir_t                 last_dir;
    logic [COST_OUT_W-1:0] get_cost;

    gne_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // shared address unit
    assign dx      = step_dx(dir_reg);
    assign dy      = step_dy(dir_reg);
    assign nx_full = {ox_reg[COORD_W-1], ox_reg} + {{(COORD_W - 1){dx[1]}}, dx};
    assign ny_full = {oy_reg[COORD_W-1], oy_reg} + {{(COORD_W - 1){dy[1]}}, dy};

    assign inb = fit_reg && !rx_reg[REL_W-1] && !ry_reg[REL_W-1]
                 && (rx_reg < wlim_reg) && (ry_reg < hlim_reg);
    assign idx = ADDR_W'(ry_reg[YW-1:0]) * ROW_PITCH + ADDR_W'(rx_reg[XW-1:0]);

    assign mem_re    = (state_reg == ST_LOOK);
    assign mem_raddr = inb ? idx : '0;

    // evaluation of the fetched entry
    assign rd33      = {{(33 - COST_BITS){mem_rdata[COST_BITS-1]}}, mem_rdata};
    assign cell_wall = inb_reg && mem_rdata[COST_BITS-1];
    assign get_cost  = (rd33 > GET_MAX33) ? {COST_OUT_W{1'b1}} : rd33[COST_OUT_W-1:0];
    assign check     = (op_reg == OP_WALK) && diag_reg && !cut_reg;
    assign is_origin = (dir_reg == DIR_ORIGIN);
    assign last_dir  = ((op_reg == OP_WALK) && diag_reg) ? DIR_LAST_ALL : DIR_LAST_CARD;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        unique case (dir_reg)
            4'd0, 4'd1, 4'd2, 4'd3: corner = owall_reg;
            4'd4:    corner = cwall_reg[0] || cwall_reg[3];
            4'd5:    corner = cwall_reg[2] || cwall_reg[1];
            4'd6:    corner = cwall_reg[2] || cwall_reg[3];
            4'd7:    corner = cwall_reg[0] || cwall_reg[1];
            default: corner = 1'b0;
        endcase
    end

    assign pass  = inb_reg && ((op_reg == OP_CARD) || (!cell_wall && !(check && corner)));
    assign stall = pass && pend_valid_reg && !out_free;

    assign mem_we    = (state_reg == ST_CLEAR)
                       || ((state_reg == ST_EVAL) && is_origin && (op_reg == OP_SET)
                           && inb_reg);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? RESET_COST : cost_in_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        dir_next        = dir_reg;
        clr_next        = clr_reg;
        left_next       = left_reg;
        top_next        = top_reg;
        wlim_next       = wlim_reg;
        hlim_next       = hlim_reg;
        diag_next       = diag_reg;
        cut_next        = cut_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        cost_in_next    = cost_in_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        fit_next        = fit_reg;
        inb_next        = inb_reg;
        idx_next        = idx_reg;
        owall_next      = owall_reg;
        cwall_next      = cwall_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_LEFT:   left_next = cfg_wdata[COORD_W-1:0];
                REG_GRID_TOP:    top_next  = cfg_wdata[COORD_W-1:0];
                REG_GRID_WIDTH:  wlim_next = dim_limit(cfg_wdata[DIM_W-1:0], WLIM_MAX);
                REG_GRID_HEIGHT: hlim_next = dim_limit(cfg_wdata[DIM_W-1:0], HLIM_MAX);
                REG_DIAGONAL:    diag_next = cfg_wdata[0];
                REG_CORNER_CUT:  cut_next  = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next      = op_t'(s_tuser);
                    ox_next      = s_tdata[COORD_W-1:0];
                    oy_next      = s_tdata[2*COORD_W-1:COORD_W];
                    cost_in_next = sat_cost(s_tdata[3*COORD_W-1:2*COORD_W]);
                    dir_next     = DIR_ORIGIN;
                    state_next   = ST_STEP;
                end
            end
            ST_STEP: begin
                nx_next    = nx_full[COORD_W-1:0];
                ny_next    = ny_full[COORD_W-1:0];
                fit_next   = (nx_full[COORD_W] == nx_full[COORD_W-1])
                             && (ny_full[COORD_W] == ny_full[COORD_W-1]);
                rx_next    = {nx_full[COORD_W], nx_full}
                             - {{2{left_reg[COORD_W-1]}}, left_reg};
                ry_next    = {ny_full[COORD_W], ny_full}
                             - {{2{top_reg[COORD_W-1]}}, top_reg};
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                inb_next   = inb;
                idx_next   = idx;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (is_origin) begin
                    unique case (op_reg)
                        OP_SET: begin
                            pend_next       = '{inb_reg ? STS_OK : STS_OUTSIDE,
                                                ox_reg, oy_reg, '0, 1'b0};
                            pend_valid_next = 1'b1;
                            state_next      = ST_FINISH;
                        end
                        OP_GET: begin
                            pend_next       = '{inb_reg ? STS_OK : STS_OUTSIDE,
                                                ox_reg, oy_reg,
                                                cell_wall ? '0 : get_cost,
                                                cell_wall};
                            if (!inb_reg) begin
                                pend_next.cost = '0;
                            end
                            pend_valid_next = 1'b1;
                            state_next      = ST_FINISH;
                        end
                        default: begin
                            owall_next = cell_wall;
                            dir_next   = DIR_FIRST;
                            state_next = ST_STEP;
                        end
                    endcase
                end else if (!stall) begin
                    if (!dir_reg[2]) begin
                        cwall_next[dir_reg[1:0]] = cell_wall;
                    end
                    if (pass) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = '{STS_OK, nx_reg, ny_reg, '0, 1'b0};
                        pend_valid_next = 1'b1;
                    end
                    if (dir_reg == last_dir) begin
                        state_next = ST_FINISH;
                    end else begin
                        dir_next   = dir_reg + 4'd1;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next        = pend_valid_reg ? pend_reg
                                                     : '{STS_NONE, ox_reg, oy_reg, '0, 1'b0};
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            op_reg         <= OP_SET;
            dir_reg        <= DIR_ORIGIN;
            clr_reg        <= '0;
            left_reg       <= '0;
            top_reg        <= '0;
            wlim_reg       <= dim_limit(DIM_RESET, WLIM_MAX);
            hlim_reg       <= dim_limit(DIM_RESET, HLIM_MAX);
            diag_reg       <= 1'b0;
            cut_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            dir_reg        <= dir_next;
            clr_reg        <= clr_next;
            left_reg       <= left_next;
            top_reg        <= top_next;
            wlim_reg       <= wlim_next;
            hlim_reg       <= hlim_next;
            diag_reg       <= diag_next;
            cut_reg        <= cut_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            ox_reg         <= ox_next;
            oy_reg         <= oy_next;
            cost_in_reg    <= cost_in_next;
            nx_reg         <= nx_next;
            ny_reg         <= ny_next;
            rx_reg         <= rx_next;
            ry_reg         <= ry_next;
            fit_reg        <= fit_next;
            inb_reg        <= inb_next;
            idx_reg        <= idx_next;
            owall_reg      <= owall_next;
            cwall_reg      <= cwall_next;
            pend_reg       <= pend_next;
            out_reg        <= out_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.imp, out_reg.cost, out_reg.y, out_reg.x};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_last_reg;

    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "ready right after an accepted item")
    `ASSERT_IMPL(a_idle_no_pending, aclk, aresetn, s_tready, !pend_valid_reg, "pending result left over while idle")
    `ASSERT_IMPL(a_store_write_src, aclk, aresetn, mem_we, (state_reg == ST_CLEAR) || ((state_reg == ST_EVAL) && (op_reg == OP_SET) && is_origin), "store written outside clear or set")
    `ASSERT_CLK(a_finish_last, aclk, aresetn, ((state_reg == ST_FINISH) && out_free) |=> (m_tvalid && m_tlast), "final result not marked last")
    `ASSERT_IMPL(a_card_dirs, aclk, aresetn, (state_reg == ST_EVAL) && (op_reg == OP_CARD), (dir_reg <= DIR_LAST_CARD) || is_origin, "diagonal visited in cardinal query")

endmodule
